// ===== rtl/isma_pkg.sv =====
// Shared types and constants for the integer stack machine.
`default_nettype none
package isma_pkg;

    localparam int OP_W       = 4;
    localparam int IMM_W      = 32;
    localparam int TOP_W      = 32;
    localparam int DEPTH_W    = 7;
    localparam int STAT_W     = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    localparam logic [OP_W-1:0] OP_CONST = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
    localparam logic [OP_W-1:0] OP_MAX   = 4'd5;
    localparam logic [OP_W-1:0] OP_MIN   = 4'd6;
    localparam logic [OP_W-1:0] OP_SWAP  = 4'd7;
    localparam logic [OP_W-1:0] OP_NEG   = 4'd8;
    localparam logic [OP_W-1:0] OP_DUP   = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDER   = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVER    = 3'd3;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd4;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic cap_b;
        logic unit_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_fetch;
        logic need_unit;
        logic unit_busy;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/isma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module isma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/isma_muldiv.sv =====
// Iterative multiplier and signed divider, one bit per cycle.
`default_nettype none
module isma_muldiv #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_div,
    input  wire logic [WORD_WIDTH-1:0] i_a,
    input  wire logic [WORD_WIDTH-1:0] i_b,
    output logic                       o_busy,
    output logic      [WORD_WIDTH-1:0] o_result
);

    localparam int W    = WORD_WIDTH;
    localparam int CNTW = $clog2(W + 1);

    logic [CNTW-1:0] r_cnt;
    logic            r_div;
    logic            r_neg;
    logic [W-1:0]    r_x;
    logic [W-1:0]    r_y;
    logic [W:0]      r_z;

    logic [W-1:0]    w_abs_a;
    logic [W-1:0]    w_abs_b;
    logic [W-1:0]    w_mul_sum;
    logic [W:0]      w_rem_sh;
    logic [W+1:0]    w_diff;

    assign w_abs_a   = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b   = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign w_mul_sum = r_z[W-1:0] + (r_y[0] ? r_x : '0);
    assign w_rem_sh  = {r_z[W-1:0], r_x[W-1]};
    assign w_diff    = {1'b0, w_rem_sh} - {2'b00, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_x   <= i_div ? w_abs_a : i_a;
            r_y   <= i_div ? w_abs_b : i_b;
            r_z   <= '0;
        end else if (r_cnt != '0) begin
            if (r_div) begin
                if (!w_diff[W+1]) begin
                    r_z <= w_diff[W:0];
                    r_x <= {r_x[W-2:0], 1'b1};
                end else begin
                    r_z <= w_rem_sh;
                    r_x <= {r_x[W-2:0], 1'b0};
                end
            end else begin
                r_z <= {1'b0, w_mul_sum};
                r_x <= {r_x[W-2:0], 1'b0};
                r_y <= {1'b0, r_y[W-1:1]};
            end
        end
    end

    assign o_busy   = (r_cnt != '0);
    assign o_result = r_div ? (r_neg ? (~r_x + 1'b1) : r_x) : r_z[W-1:0];

endmodule
`default_nettype wire

// ===== rtl/isma_datapath.sv =====
// Datapath: cached stack top, stack RAM, ALU, mul/div unit and result register.
`default_nettype none
module isma_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_WIDTH  = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire isma_pkg::t_cmd                i_cmd,
    output isma_pkg::t_sts                     o_sts,
    input  wire logic [isma_pkg::OP_W-1:0]     i_op,
    input  wire logic [isma_pkg::IMM_W-1:0]    i_imm,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic      [isma_pkg::TOP_W-1:0]    o_top_value,
    output logic      [isma_pkg::DEPTH_W-1:0]  o_depth,
    output logic      [isma_pkg::STAT_W-1:0]   o_status
);

    import isma_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [OP_W-1:0]    r_op;
    logic [W-1:0]       r_imm;
    logic [CW-1:0]      r_count;
    logic [W-1:0]       r_top;
    logic [W-1:0]       r_b;
    logic               r_m_tvalid;
    logic [TOP_W-1:0]   r_m_top;
    logic [DEPTH_W-1:0] r_m_depth;
    logic [STAT_W-1:0]  r_m_status;

    logic [CW-1:0]      n_count;
    logic [W-1:0]       n_top;
    logic [STAT_W-1:0]  w_status;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [W-1:0]       w_rdata;
    logic [W-1:0]       w_unit_res;
    logic               w_unit_busy;
    logic [W-1:0]       w_alu;
    logic [W+IMM_W-1:0] w_imm_sx;
    logic [CW-1:0]      w_cnt_m1;
    logic [CW-1:0]      w_cnt_m2;
    logic               w_empty;
    logic               w_full;
    logic               w_two;
    logic               w_is_bin;
    logic               w_lt;
    logic [TOP_W+W-1:0]     w_top_ext;
    logic [DEPTH_W+CW-1:0]  w_depth_ext;

    assign w_imm_sx = {{W{i_imm[IMM_W-1]}}, i_imm};
    assign w_cnt_m1 = r_count - 1'b1;
    assign w_cnt_m2 = r_count - 2'd2;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CW'(STACK_DEPTH));
    assign w_two    = (r_count >= CW'(2));
    assign w_is_bin = (r_op >= OP_ADD) && (r_op <= OP_SWAP);
    assign w_lt     = $signed(r_top) < $signed(r_b);

    always_comb begin
        case (r_op)
            OP_ADD:  w_alu = r_top + r_b;
            OP_SUB:  w_alu = r_top - r_b;
            OP_MUL:  w_alu = w_unit_res;
            OP_DIV:  w_alu = w_unit_res;
            OP_MAX:  w_alu = w_lt ? r_b : r_top;
            OP_MIN:  w_alu = w_lt ? r_top : r_b;
            default: w_alu = r_top;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        w_status = ST_OK;
        w_we     = 1'b0;
        w_waddr  = w_cnt_m1[AW-1:0];
        case (r_op)
            OP_CONST: begin
                if (w_full) begin
                    w_status = ST_OVER;
                end else begin
                    w_we    = !w_empty;
                    n_count = r_count + 1'b1;
                    n_top   = r_imm;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN: begin
                if (!w_two) begin
                    w_status = ST_IGNORED;
                end else if (r_op == OP_DIV && r_b == '0) begin
                    w_status = ST_DIVZERO;
                end else begin
                    n_count = w_cnt_m1;
                    n_top   = w_alu;
                end
            end
            OP_SWAP: begin
                if (!w_two) begin
                    w_status = ST_IGNORED;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_cnt_m2[AW-1:0];
                    n_top   = r_b;
                end
            end
            OP_NEG: begin
                if (w_empty) begin
                    w_status = ST_UNDER;
                end else begin
                    n_top = ~r_top + 1'b1;
                end
            end
            OP_DUP: begin
                if (w_empty) begin
                    w_status = ST_UNDER;
                end else if (w_full) begin
                    w_status = ST_OVER;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                w_status = ST_IGNORED;
            end
        endcase
    end

    assign w_top_ext   = {{TOP_W{1'b0}}, n_top};
    assign w_depth_ext = {{DEPTH_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_imm <= w_imm_sx[W-1:0];
        end
        if (i_cmd.cap_b) begin
            r_b <= w_rdata;
        end
        if (i_cmd.commit) begin
            r_top      <= n_top;
            r_m_top    <= (n_count == '0) ? '0 : w_top_ext[TOP_W-1:0];
            r_m_depth  <= w_depth_ext[DEPTH_W-1:0];
            r_m_status <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count    <= n_count;
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    isma_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_we & i_cmd.commit),
        .i_waddr (w_waddr),
        .i_wdata (r_top),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_cnt_m2[AW-1:0]),
        .o_rdata (w_rdata)
    );

    isma_muldiv #(
        .WORD_WIDTH (W)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.unit_start),
        .i_div    (r_op == OP_DIV),
        .i_a      (r_top),
        .i_b      (w_rdata),
        .o_busy   (w_unit_busy),
        .o_result (w_unit_res)
    );

    assign o_sts.need_fetch = w_is_bin && w_two;
    assign o_sts.need_unit  = (r_op == OP_MUL) || (r_op == OP_DIV && w_rdata != '0);
    assign o_sts.unit_busy  = w_unit_busy;
    assign o_sts.out_free   = !r_m_tvalid || i_m_tready;

    assign o_m_tvalid  = r_m_tvalid;
    assign o_top_value = r_m_top;
    assign o_depth     = r_m_depth;
    assign o_status    = r_m_status;

endmodule
`default_nettype wire

// ===== rtl/isma_ctrl.sv =====
// Controller state machine sequencing one instruction at a time.
`default_nettype none
module isma_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire isma_pkg::t_sts i_sts,
    output isma_pkg::t_cmd      o_cmd
);

    import isma_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_MWAIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.need_fetch) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_FETCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FETCH: begin
                o_cmd.cap_b = 1'b1;
                if (i_sts.need_unit) begin
                    o_cmd.unit_start = 1'b1;
                    n_state          = S_MWAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MWAIT: begin
                if (!i_sts.unit_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_s_tready = r_ready;

endmodule
`default_nettype wire

// ===== rtl/integer_stack_machine.sv =====
// Top level of the integer stack machine.
//
// One instruction per slave transfer: tdata [3:0] op, [35:4] immediate.
// One result per instruction on the master side: tdata [31:0] top of stack
// (zero when empty), [38:32] depth, [41:39] status.
// The stack top sits in a register; the entries below it live in a
// single-port-write RAM, so binary ops and SWAP need a RAM read.
// Each instruction is loaded, decoded and then committed; binary ops and
// SWAP with two entries also pass through FETCH for the RAM read, and
// MUL and DIV with a nonzero divisor then wait in MWAIT on the
// one-bit-per-cycle mul/div unit.
// One instruction is in flight at a time; the next is accepted once the
// previous result is in the output register.
// A stalled receiver holds the result register; a finished instruction then
// waits before committing, and tready stays low meanwhile.
// Reset empties the stack and clears the output valid; RAM contents are
// not cleared since entries above the depth are never read.
`default_nettype none
module integer_stack_machine #(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_WIDTH  = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [isma_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // op, immediate
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic      [isma_pkg::M_TDATA_W-1:0]   o_m_axis_tdata   // top_value, depth, status
);

    import isma_pkg::*;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [TOP_W-1:0]   w_top;
    logic [DEPTH_W-1:0] w_depth;
    logic [STAT_W-1:0]  w_status;

    isma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    isma_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_op        (i_s_axis_tdata[OP_W-1:0]),
        .i_imm       (i_s_axis_tdata[OP_W+IMM_W-1:OP_W]),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_top_value (w_top),
        .o_depth     (w_depth),
        .o_status    (w_status)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W-TOP_W-DEPTH_W-STAT_W){1'b0}},
                             w_status, w_depth, w_top};

endmodule
`default_nettype wire

// ===== rtl/isma_checker.sv =====
// Port-level checker for the integer stack machine, with its bind.
`default_nettype none
module isma_checker #(
    parameter int STACK_DEPTH = 64
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [isma_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    import isma_pkg::*;

    logic [TOP_W-1:0]   w_top;
    logic [DEPTH_W-1:0] w_depth;
    logic [STAT_W-1:0]  w_status;

    assign w_top    = o_m_axis_tdata[TOP_W-1:0];
    assign w_depth  = o_m_axis_tdata[TOP_W+DEPTH_W-1:TOP_W];
    assign w_status = o_m_axis_tdata[TOP_W+DEPTH_W+STAT_W-1:TOP_W+DEPTH_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("depth beyond stack size");

    a_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_status == ST_OVER |-> w_depth == DEPTH_W'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_status == ST_UNDER || w_depth == '0)
            |-> w_depth == '0 && w_top == '0)
        else $error("empty stack with nonzero top or underflow with entries");

endmodule

bind integer_stack_machine isma_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_isma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

// ===== tb/integer_stack_machine_tb.sv =====
`timescale 1ns / 100ps
// Testbench for integer_stack_machine: runs instruction streams and checks each result against a stack predictor.
module integer_stack_machine_tb;
    import isma_pkg::*;

    localparam int STACK_LIMIT = 64;
    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_HOLD = 300;
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic signed [TOP_W-1:0] top;
        logic [DEPTH_W-1:0]      depth;
        logic [STAT_W-1:0]       status;
    } t_stack_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // op, immediate
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // top_value, depth, status

    logic [S_TDATA_W-1:0] instr_queue[$];
    t_stack_result        expected_results[$];

    // predictor state
    logic signed [TOP_W-1:0] stack_words[STACK_LIMIT];
    int                      stack_depth = 0;

    int gen_depth = 0;
    int mismatch_count = 0;
    int sent_count = 0;
    int send_gap = 0;
    int result_count = 0;
    int recv_stall = 0;
    bit long_hold_done = 1'b0;

    integer_stack_machine #(
        .STACK_DEPTH(STACK_LIMIT),
        .WORD_WIDTH (TOP_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Executes one instruction on the predictor stack and returns the expected result.
    function automatic t_stack_result exec_instr(input logic [S_TDATA_W-1:0] word);
        logic [OP_W-1:0]         op;
        logic signed [TOP_W-1:0] imm;
        logic signed [TOP_W-1:0] a;
        logic signed [TOP_W-1:0] b;
        logic signed [TOP_W-1:0] r;
        logic [STAT_W-1:0]       st;
        longint                  qa;
        longint                  qb;
        t_stack_result           res;
        op = word[OP_W-1:0];
        imm = word[OP_W +: IMM_W];
        st = ST_OK;
        a = '0;
        b = '0;
        r = '0;
        if (stack_depth >= 1) a = stack_words[stack_depth-1];
        if (stack_depth >= 2) b = stack_words[stack_depth-2];
        case (op)
            OP_CONST: begin
                if (stack_depth >= STACK_LIMIT) st = ST_OVER;
                else begin
                    stack_words[stack_depth] = imm;
                    stack_depth++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN, OP_SWAP: begin
                if (stack_depth < 2) st = ST_IGNORED;
                else begin
                    case (op)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        OP_DIV: begin
                            if (b == 0) st = ST_DIVZERO;
                            else begin
                                qa = a;
                                qb = b;
                                r = qa / qb;
                            end
                        end
                        OP_MAX: r = (a < b) ? b : a;
                        OP_MIN: r = (a < b) ? a : b;
                        default: r = '0;
                    endcase
                    if (op == OP_SWAP) begin
                        stack_words[stack_depth-1] = b;
                        stack_words[stack_depth-2] = a;
                    end else if (st == ST_OK) begin
                        stack_words[stack_depth-2] = r;
                        stack_depth--;
                    end
                end
            end
            OP_NEG: begin
                if (stack_depth == 0) st = ST_UNDER;
                else stack_words[stack_depth-1] = -a;
            end
            OP_DUP: begin
                if (stack_depth == 0) st = ST_UNDER;
                else if (stack_depth >= STACK_LIMIT) st = ST_OVER;
                else begin
                    stack_words[stack_depth] = a;
                    stack_depth++;
                end
            end
            default: st = ST_IGNORED;
        endcase
        res.top = (stack_depth > 0) ? stack_words[stack_depth-1] : '0;
        res.depth = stack_depth[DEPTH_W-1:0];
        res.status = st;
        return res;
    endfunction

    // rough depth tracking only steers the random mix
    task automatic queue_instr(input logic [OP_W-1:0] op, input logic [IMM_W-1:0] imm);
        instr_queue.push_back({{(S_TDATA_W-OP_W-IMM_W){1'b0}}, imm, op});
        case (op)
            OP_CONST: if (gen_depth < STACK_LIMIT) gen_depth++;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN: if (gen_depth >= 2) gen_depth--;
            OP_DUP: if (gen_depth > 0 && gen_depth < STACK_LIMIT) gen_depth++;
            default: ;
        endcase
    endtask

    function automatic logic [IMM_W-1:0] rand_operand();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin : driver
        bit offering;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            offering = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(exec_instr(s_tdata));
                sent_count++;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (instr_queue.size() >= 60 && (sent_count / 50) % 3 != 2 &&
                             $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 12) - 1;
                    s_tvalid <= 1'b0;
                end else if (instr_queue.size() > 0) begin
                    s_tdata <= instr_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        t_stack_result got;
        t_stack_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.top = m_tdata[TOP_W-1:0];
                got.depth = m_tdata[TOP_W +: DEPTH_W];
                got.status = m_tdata[TOP_W+DEPTH_W +: STAT_W];
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result top %0d depth %0d status %0d",
                                              got.top, got.depth, got.status));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "result %0d: top %0d depth %0d status %0d, expected %0d %0d %0d",
                            result_count, got.top, got.depth, got.status,
                            want.top, want.depth, want.status));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && result_count >= 100) begin
                // long hold-off: input side must back up
                long_hold_done = 1'b1;
                recv_stall = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (instr_queue.size() >= 60 && (result_count / 50) % 3 != 2 &&
                         $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [OP_W-1:0] op;
        int              pick;
        int              fill;
        // empty-stack and too-few cases
        queue_instr(OP_NEG, 32'h0000_0000);
        queue_instr(OP_DUP, 32'hFFFF_FFFF);
        queue_instr(OP_ADD, 32'h0000_0000);
        queue_instr(OP_UNUSED_HI, 32'hFFFF_FFFF);
        // zero divisor, swap, sub
        queue_instr(OP_CONST, 32'h0000_0000);
        queue_instr(OP_CONST, 32'h0000_0005);
        queue_instr(OP_DIV, 32'h0000_0000);
        queue_instr(OP_SWAP, 32'h0000_0000);
        queue_instr(OP_SUB, 32'h0000_0000);
        queue_instr(OP_SWAP, 32'h0000_0000);
        // most negative over minus one, negate most negative
        queue_instr(OP_CONST, 32'hFFFF_FFFF);
        queue_instr(OP_CONST, 32'h8000_0000);
        queue_instr(OP_DIV, 32'h0000_0000);
        queue_instr(OP_NEG, 32'h0000_0000);
        queue_instr(OP_DUP, 32'h0000_0000);
        queue_instr(OP_ADD, 32'h0000_0000);
        // multiply wrap, max, min, truncating divide
        queue_instr(OP_CONST, 32'h7FFF_FFFF);
        queue_instr(OP_DUP, 32'h0000_0000);
        queue_instr(OP_MUL, 32'h0000_0000);
        queue_instr(OP_MAX, 32'h0000_0000);
        queue_instr(OP_MIN, 32'h0000_0000);
        queue_instr(OP_CONST, 32'h0000_0007);
        queue_instr(OP_CONST, 32'hFFFF_FFEC);
        queue_instr(OP_DIV, 32'h0000_0000);
        queue_instr(OP_UNUSED_LO, 32'h0000_0000);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                // fill to the limit and push past it
                for (fill = 0; fill < STACK_LIMIT + 4; fill++)
                    queue_instr(($urandom_range(0, 3) == 0) ? OP_DUP : OP_CONST, rand_operand());
                queue_instr(OP_CONST, rand_operand());
                queue_instr(OP_DUP, rand_operand());
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else if (gen_depth < 2 && pick < 70) op = (gen_depth == 1 && pick < 20) ? OP_DUP
                                                                                    : OP_CONST;
            else if (gen_depth > 40 && pick < 60) op = OP_W'($urandom_range(OP_ADD, OP_MIN));
            else op = OP_W'($urandom_range(OP_CONST, OP_DUP));
            queue_instr(op, rand_operand());
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_queue.size() != 0 || s_tvalid) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== integer_stack_machine.f =====
rtl/isma_pkg.sv
rtl/isma_ram.sv
rtl/isma_muldiv.sv
rtl/isma_datapath.sv
rtl/isma_ctrl.sv
rtl/integer_stack_machine.sv
rtl/isma_checker.sv
tb/integer_stack_machine_tb.sv
